[sv/pixel_brightness_contrast_defines.svh]
// ----------------------------------------------------------------------------
// pixel_brightness_contrast_defines
// assertion helpers shared by the brightness/contrast block
// ----------------------------------------------------------------------------
`ifndef PIXEL_BRIGHTNESS_CONTRAST_DEFINES_SVH
`define PIXEL_BRIGHTNESS_CONTRAST_DEFINES_SVH

// same-cycle implication, clocked on clk, off while in reset
`define PBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off while in reset
`define PBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pbc_pkg.sv]
// ----------------------------------------------------------------------------
// pbc_pkg
// shared types and constants of the brightness/contrast block
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int PIX_W          = 8;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = 24;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 9;

  // 259*(c+255) peaks at 132090, 255*(259-c) at 131070
  localparam int NUM_BASE_W = 18;
  localparam int DEN_W      = 17;
  localparam int NUM_W      = NUM_BASE_W + GAIN_FRAC_BITS;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int PROD_W     = GAIN_W + PIX_W;
  localparam int QM_W       = PROD_W + 1 - GAIN_FRAC_BITS;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS   = 2'd0,
    REG_CONTRAST     = 2'd1,
    REG_CHANNEL_MODE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_ALL   = 2'd0,
    MODE_RED   = 2'd1,
    MODE_GREEN = 2'd2,
    MODE_BLUE  = 2'd3
  } chan_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] a;
  } pix_t;

  typedef struct packed {
    logic              busy;
    logic [GAIN_W-1:0] gain;
  } gain_stat_t;

endpackage

[sv/pbc_in_if.sv]
// ----------------------------------------------------------------------------
// pbc_in_if
// pixel request channel into the block
// ----------------------------------------------------------------------------
interface pbc_in_if;
  import pbc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic [PIX_W-1:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

[sv/pbc_out_if.sv]
// ----------------------------------------------------------------------------
// pbc_out_if
// adjusted pixel channel out of the block
// ----------------------------------------------------------------------------
interface pbc_out_if;
  import pbc_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic [PIX_W-1:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

[sv/pbc_cfg_if.sv]
// ----------------------------------------------------------------------------
// pbc_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface pbc_cfg_if;
  import pbc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/pixel_brightness_contrast.sv]
// ----------------------------------------------------------------------------
// pixel_brightness_contrast
// brightness and contrast adjustment of an RGBA pixel stream
//
// usage:
//   in_px  : one RGBA pixel per request, taken when valid and ready are high
//   out_px : one adjusted pixel per request, alpha copied through
//   cfg_wr : register writes, 0 brightness, 1 contrast, 2 channel mode;
//            index 3 is ignored
// path: a pixel taken goes into the input register, then into the result
//   register, which drives out_px
// throughput: one pixel per cycle unless out_px stalls or a gain update runs;
//   the result register frees the input register while the receiver drains it
// stall: if out_px is held off, the input register keeps one more pixel,
//   then in_px.ready drops until the result register empties
// contrast write: the gain is refreshed by a bit-serial divider; in_px and
//   cfg_wr are not ready meanwhile
// reset: synchronous, active low; both stages empty, registers zero,
//   gain set to one
// ----------------------------------------------------------------------------
`include "pixel_brightness_contrast_defines.svh"

module pixel_brightness_contrast (
  input  logic       clk,
  input  logic       rst_n,
  pbc_in_if.sink     in_px,
  pbc_out_if.source  out_px,
  pbc_cfg_if.sink    cfg_wr
);
  import pbc_pkg::*;

  // configuration
  logic [8:0]   brightness_r, brightness_nxt;
  chan_mode_t   mode_r, mode_nxt;
  logic         cfg_acc;
  logic         gain_start;
  gain_stat_t   gain_st;

  // pipeline
  pix_t         s1_r;
  logic         s1_vld_r, s1_vld_nxt;
  pix_t         out_r, out_nxt;
  logic         out_vld_r, out_vld_nxt;
  logic         adv;
  logic         in_acc;
  logic         sel_r, sel_g, sel_b;
  logic [PIX_W-1:0] adj_r, adj_g, adj_b;

  // ---------------- register writes ----------------
  assign cfg_wr.ready = !gain_st.busy;
  assign cfg_acc      = cfg_wr.valid && cfg_wr.ready;

  always_comb begin
    brightness_nxt = brightness_r;
    mode_nxt       = mode_r;
    gain_start     = 1'b0;
    if (cfg_acc) begin
      case (cfg_idx_t'(cfg_wr.index))
        REG_BRIGHTNESS:   brightness_nxt = cfg_wr.data;
        REG_CONTRAST:     gain_start     = 1'b1;
        REG_CHANNEL_MODE: mode_nxt       = chan_mode_t'(cfg_wr.data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= '0;
      mode_r       <= MODE_ALL;
    end else begin
      brightness_r <= brightness_nxt;
      mode_r       <= mode_nxt;
    end
  end

  // gain is recomputed on every contrast write
  pbc_gain_div u_gain_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (gain_start),
    .contrast (cfg_wr.data),
    .stat     (gain_st)
  );

  // ---------------- handshake ----------------
  // the pipe moves whenever the result register is empty or being drained
  assign adv         = !out_vld_r || out_px.ready;
  assign in_px.ready = !gain_st.busy && (!s1_vld_r || adv);
  assign in_acc      = in_px.valid && in_px.ready;

  // ---------------- channel select ----------------
  always_comb begin
    sel_r = 1'b0;
    sel_g = 1'b0;
    sel_b = 1'b0;
    case (mode_r)
      MODE_ALL: begin
        sel_r = 1'b1;
        sel_g = 1'b1;
        sel_b = 1'b1;
      end
      MODE_RED:   sel_r = 1'b1;
      MODE_GREEN: sel_g = 1'b1;
      MODE_BLUE:  sel_b = 1'b1;
      default: ;
    endcase
  end

  pbc_chan_adj u_adj_r (
    .pix_in     (s1_r.r),
    .brightness (brightness_r),
    .gain       (gain_st.gain),
    .pix_out    (adj_r)
  );

  pbc_chan_adj u_adj_g (
    .pix_in     (s1_r.g),
    .brightness (brightness_r),
    .gain       (gain_st.gain),
    .pix_out    (adj_g)
  );

  pbc_chan_adj u_adj_b (
    .pix_in     (s1_r.b),
    .brightness (brightness_r),
    .gain       (gain_st.gain),
    .pix_out    (adj_b)
  );

  // ---------------- pipeline registers ----------------
  always_comb begin
    s1_vld_nxt  = in_acc || (s1_vld_r && !adv);
    out_vld_nxt = adv ? s1_vld_r : out_vld_r;

    // zero alpha passes the pixel untouched
    out_nxt = s1_r;
    if (s1_r.a != '0) begin
      if (sel_r) out_nxt.r = adj_r;
      if (sel_g) out_nxt.g = adj_g;
      if (sel_b) out_nxt.b = adj_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r.r <= in_px.red_in;
      s1_r.g <= in_px.green_in;
      s1_r.b <= in_px.blue_in;
      s1_r.a <= in_px.alpha_in;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_px.valid     = out_vld_r;
  assign out_px.red_out   = out_r.r;
  assign out_px.green_out = out_r.g;
  assign out_px.blue_out  = out_r.b;
  assign out_px.alpha_out = out_r.a;

  // ---------------- assertions ----------------
  `PBC_ASSERT_NOW(a_no_pix_while_div, in_acc, !gain_st.busy,
                  "pixel taken during gain update")
  `PBC_ASSERT_NEXT(a_div_starts, cfg_acc && (cfg_wr.index == REG_CONTRAST), gain_st.busy,
                   "contrast write did not start divider")
  `PBC_ASSERT_NOW(a_cfg_held, gain_st.busy, !cfg_wr.ready,
                  "write port open during gain update")
  `PBC_ASSERT_NEXT(a_alpha_pass, adv && s1_vld_r && (s1_r.a == '0), out_r == $past(s1_r),
                   "zero-alpha pixel altered")

endmodule

[sv/pbc_gain_div.sv]
// ----------------------------------------------------------------------------
// pbc_gain_div
// contrast gain: restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pbc_gain_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pbc_pkg::CFG_DATA_W-1:0] contrast,
  output pbc_pkg::gain_stat_t            stat
);
  import pbc_pkg::*;

  logic                    busy_r, busy_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [DEN_W-1:0]        rem_r, rem_nxt;
  logic [NUM_W-1:0]        quo_r, quo_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic [GAIN_W-1:0]       gain_r, gain_nxt;

  logic signed [9:0]       c_ext;
  logic [8:0]              c_plus;
  logic [9:0]              c_minus;
  logic [NUM_BASE_W-1:0]   num_base;
  logic [DEN_W:0]          trial;
  logic [DEN_W:0]          diff;
  logic                    q_bit;

  always_comb begin
    // the one pattern below range is taken as -255
    if (contrast == 9'h100) begin
      c_ext = -10'sd255;
    end else begin
      c_ext = {contrast[8], contrast};
    end
    c_plus   = 9'(c_ext + 10'sd255);
    c_minus  = 10'(10'sd259 - c_ext);
    num_base = NUM_BASE_W'(c_plus) * NUM_BASE_W'(259);

    trial = {rem_r, quo_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    q_bit = (trial >= {1'b0, den_r});

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    gain_nxt = gain_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = {num_base, {GAIN_FRAC_BITS{1'b0}}};
      den_nxt  = DEN_W'(c_minus) * DEN_W'(255);
    end else if (busy_r) begin
      if (cnt_r == CNT_W'(NUM_W)) begin
        busy_nxt = 1'b0;
        if (quo_r[NUM_W-1:GAIN_W] != '0) begin
          gain_nxt = GAIN_MAX;
        end else begin
          gain_nxt = quo_r[GAIN_W-1:0];
        end
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
        rem_nxt = q_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], q_bit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      gain_r <= GAIN_ONE;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      gain_r <= gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.gain = gain_r;

endmodule

[sv/pbc_chan_adj.sv]
// ----------------------------------------------------------------------------
// pbc_chan_adj
// one colour channel: brightness offset, clamp, gain about mid-grey, clamp
// ----------------------------------------------------------------------------
module pbc_chan_adj (
  input  logic [pbc_pkg::PIX_W-1:0]  pix_in,
  input  logic [8:0]                 brightness,
  input  logic [pbc_pkg::GAIN_W-1:0] gain,
  output logic [pbc_pkg::PIX_W-1:0]  pix_out
);
  import pbc_pkg::*;

  logic signed [9:0]  sum;
  logic [PIX_W-1:0]   lvl;
  logic               below;
  logic [PIX_W-1:0]   span;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    prod_up;
  logic [QM_W-1:0]    qm;

  always_comb begin
    sum = $signed({2'b00, pix_in}) + $signed({brightness[8], brightness});
    if (sum < 0) begin
      lvl = '0;
    end else if (sum > 10'sd255) begin
      lvl = 8'd255;
    end else begin
      lvl = sum[7:0];
    end

    below = (lvl < 8'd128);
    span  = below ? 8'(8'd128 - lvl) : 8'(lvl - 8'd128);
    prod  = PROD_W'(gain) * PROD_W'(span);

    // negative side rounds the magnitude up so the signed result floors
    prod_up = {1'b0, prod} + (PROD_W + 1)'({GAIN_FRAC_BITS{1'b1}});
    if (below) begin
      qm = prod_up[PROD_W:GAIN_FRAC_BITS];
    end else begin
      qm = {1'b0, prod[PROD_W-1:GAIN_FRAC_BITS]};
    end

    if (qm > QM_W'(127)) begin
      pix_out = below ? 8'd0 : 8'd255;
    end else if (below) begin
      pix_out = 8'(8'd128 - qm[7:0]);
    end else begin
      pix_out = 8'(8'd128 + qm[7:0]);
    end
  end

endmodule

[dv/pbc_pixel_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbc_pixel_checker
// watches the pixel, result and register channels of the brightness/contrast
// block, keeps its own copy of the registers and gain, works out each
// adjusted pixel and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module pbc_pixel_checker (
  input  logic        clk,
  input  logic        rst_n,
  pbc_in_if           in_mon,
  pbc_out_if          out_mon,
  pbc_cfg_if          cfg_mon,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned checked
);
  import pbc_pkg::*;

  logic [CFG_DATA_W-1:0] bright_setting;
  logic [GAIN_W-1:0]     gain_q;
  chan_mode_t            mode_setting;
  pix_t                  expected_pixels[$];
  string                 field_names[4] = '{"red", "green", "blue", "alpha"};

  // unsigned fixed-point contrast gain, rounded down, saturating
  function automatic logic [GAIN_W-1:0] gain_for(logic [CFG_DATA_W-1:0] setting);
    longint c, num, den, g;
    c = longint'($signed(setting));
    if (c < -255) c = -255;
    num = (259 * (c + 255)) <<< GAIN_FRAC_BITS;
    den = 255 * (259 - c);
    g   = num / den;
    if (g > longint'(GAIN_MAX)) g = longint'(GAIN_MAX);
    return GAIN_W'(g);
  endfunction

  function automatic logic [PIX_W-1:0] clamp_pix(longint v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return PIX_W'(v);
  endfunction

  // offset, clamp, then scale about mid-grey with a floored product
  function automatic logic [PIX_W-1:0] tone_map(logic [PIX_W-1:0] v);
    longint lifted, scaled;
    lifted = longint'(clamp_pix(longint'(v) + longint'($signed(bright_setting)))) - 128;
    scaled = (longint'(gain_q) * lifted) >>> GAIN_FRAC_BITS;
    return clamp_pix(scaled + 128);
  endfunction

  function automatic pix_t adjust_pixel(pix_t px);
    pix_t res;
    res = px;
    if (px.a != '0) begin
      if (mode_setting == MODE_ALL || mode_setting == MODE_RED)   res.r = tone_map(px.r);
      if (mode_setting == MODE_ALL || mode_setting == MODE_GREEN) res.g = tone_map(px.g);
      if (mode_setting == MODE_ALL || mode_setting == MODE_BLUE)  res.b = tone_map(px.b);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    pix_t got, want;
    if (!rst_n) begin
      bright_setting <= '0;
      gain_q         <= GAIN_ONE;
      mode_setting   <= MODE_ALL;
      expected_pixels.delete();
      mismatches     <= 0;
      outstanding    <= 0;
      checked        <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_BRIGHTNESS:   bright_setting <= cfg_mon.data;
          REG_CONTRAST:     gain_q <= gain_for(cfg_mon.data);
          REG_CHANNEL_MODE: mode_setting <= chan_mode_t'(cfg_mon.data[1:0]);
          default: ;
        endcase
      end

      // results first: a request taken at this edge cannot already be out
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.red_out, out_mon.green_out, out_mon.blue_out, out_mon.alpha_out};
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_pixels.pop_front();
          checked <= checked + 1;
          if (got !== want) begin
            mismatches <= mismatches + 1;
            for (int k = 0; k < 4; k++) begin
              if (got[4*PIX_W-1-PIX_W*k -: PIX_W] !== want[4*PIX_W-1-PIX_W*k -: PIX_W])
                $display("%0t: %s expected %0d, got %0d", $time, field_names[k],
                         want[4*PIX_W-1-PIX_W*k -: PIX_W], got[4*PIX_W-1-PIX_W*k -: PIX_W]);
            end
          end
        end
      end

      if (in_mon.valid && in_mon.ready)
        expected_pixels.push_back(adjust_pixel({in_mon.red_in, in_mon.green_in,
                                                in_mon.blue_in, in_mon.alpha_in}));
      outstanding <= expected_pixels.size();
    end
  end

endmodule

[dv/tb_pixel_brightness_contrast.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_brightness_contrast
// drives pixel requests and register writes into the brightness/contrast
// block: a directed pass over the extreme pixels and register settings,
// then phases of random pixels under changing settings, with random idling
// on both sides, one long receiver hold-off and a stretch with no idling;
// checking is done by pbc_pixel_checker, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_pixel_brightness_contrast;
  import pbc_pkg::*;

  localparam int unsigned IDLE_PCT     = 18;   // idle chance per cycle, each side
  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int unsigned STALL_LIMIT  = 2000; // cycles with no request moving
  localparam int unsigned DRAIN_CYCLES = 10;   // settle time after the last result
  localparam int unsigned PHASES       = 16;
  localparam int unsigned PHASE_ITEMS  = 100;

  // index 3 has no register behind it, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // register settings at the edges of range
  localparam logic [CFG_DATA_W-1:0] SET_MAX   = 9'd255;
  localparam logic [CFG_DATA_W-1:0] SET_MIN   = 9'h101;  // -255
  localparam logic [CFG_DATA_W-1:0] SET_BELOW = 9'h100;  // -256, one below range

  logic        clk;
  logic        rst_n;
  logic        calm;      // no idling on either side while high
  logic        hold_req;  // rising edge starts the long receiver hold-off
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned pixels_sent;
  int unsigned settings_applied;

  pbc_in_if  in_ch();
  pbc_out_if out_ch();
  pbc_cfg_if cfg_ch();

  pixel_brightness_contrast uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_ch),
    .out_px (out_ch),
    .cfg_wr (cfg_ch)
  );

  pbc_pixel_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (results_checked)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // one register write; valid is left high so back-to-back writes
  // never lower and raise it in the same step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // full register set, only ever called with the block drained
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] bright,
                               input logic [CFG_DATA_W-1:0] contr,
                               input chan_mode_t mode);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    write_reg(REG_BRIGHTNESS, bright);
    write_reg(REG_CONTRAST, contr);
    write_reg(REG_CHANNEL_MODE, CFG_DATA_W'(mode));
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  // offer one pixel, with random idle cycles in front unless calm
  task automatic send_pixel(input pix_t px);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.red_in, in_ch.green_in, in_ch.blue_in, in_ch.alpha_in} <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pixels_sent++;
  endtask

  // first edge lets the checker see a request taken at the previous edge
  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off counted here, calm stretch
  initial begin : result_sink
    int unsigned hold_left;
    logic        hold_seen;
    hold_left    = 0;
    hold_seen    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_seen) begin
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
      hold_seen = hold_req;
    end
  end

  // watchdog: any request moving on any channel resets the count
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, quiet);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : stimulus
    pix_t px;
    rst_n            = 1'b0;
    calm             = 1'b0;
    hold_req         = 1'b0;
    pixels_sent      = 0;
    settings_applied = 0;
    in_ch.valid      = 1'b0;
    in_ch.red_in     = '0;
    in_ch.green_in   = '0;
    in_ch.blue_in    = '0;
    in_ch.alpha_in   = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: gain of one, no offset, all channels
    send_pixel({8'h00, 8'h00, 8'h00, 8'hff});
    send_pixel({8'hff, 8'hff, 8'hff, 8'hff});
    send_pixel({8'h80, 8'h7f, 8'h81, 8'h01});
    send_pixel({8'h55, 8'haa, 8'h0f, 8'hf0});
    send_pixel({8'haa, 8'h55, 8'hf0, 8'h0f});
    in_ch.valid <= 1'b0;

    // strongest offset and contrast; zero alpha must pass untouched
    wait_drained();
    apply_setting(SET_MAX, SET_MAX, MODE_ALL);
    send_pixel({8'h00, 8'h7f, 8'hff, 8'h01});
    send_pixel({8'h12, 8'hef, 8'h80, 8'h00});
    in_ch.valid <= 1'b0;

    // both registers one below range: contrast gives zero gain, red only
    wait_drained();
    apply_setting(SET_BELOW, SET_BELOW, MODE_RED);
    send_pixel({8'hff, 8'hff, 8'hff, 8'hff});
    send_pixel({8'h01, 8'h80, 8'hfe, 8'h80});
    in_ch.valid <= 1'b0;

    // lowest in-range settings, green only
    wait_drained();
    apply_setting(SET_MIN, SET_MIN, MODE_GREEN);
    send_pixel({8'hff, 8'hff, 8'hff, 8'hff});
    send_pixel({8'h00, 8'h80, 8'hff, 8'h7f});
    in_ch.valid <= 1'b0;

    // moderate settings, blue only
    wait_drained();
    apply_setting(9'd40, 9'd128, MODE_BLUE);
    send_pixel({8'h10, 8'h90, 8'hc8, 8'h33});
    send_pixel({8'hc8, 8'h10, 8'h90, 8'h00});
    in_ch.valid <= 1'b0;

    // negative offset with reduced contrast
    wait_drained();
    apply_setting(-9'sd40, -9'sd100, MODE_ALL);
    send_pixel({8'h80, 8'h80, 8'h80, 8'hff});
    send_pixel({8'h00, 8'hff, 8'h40, 8'h01});
    in_ch.valid <= 1'b0;

    // random phases; the sender pauses until all results are back before
    // each new setting
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      case (p)
        0:       apply_setting(SET_MIN, SET_MAX, MODE_ALL);
        1:       apply_setting(SET_MAX, SET_BELOW, MODE_RED);
        2:       apply_setting(SET_BELOW, SET_MIN, MODE_BLUE);
        default: apply_setting(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                               chan_mode_t'($urandom_range(3)));
      endcase
      // phase 4: receiver holds off while pixels keep coming, so the block
      // fills and stalls its input; phases 6 and 7 run with no idling
      hold_req <= (p == 4);
      calm     <= (p == 6 || p == 7);
      repeat (PHASE_ITEMS) begin
        px = pix_t'($urandom);
        if ($urandom_range(99) < 15) begin
          // around mid-grey, where the contrast rounding matters most
          px.r = PIX_W'($urandom_range(144, 112));
          px.g = PIX_W'($urandom_range(144, 112));
          px.b = PIX_W'($urandom_range(144, 112));
        end
        if ($urandom_range(99) < 10) px.a = '0;
        send_pixel(px);
      end
      in_ch.valid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d pixels under %0d register settings, every channel mode,",
             pixels_sent, settings_applied);
    $display("a long receiver hold-off and a stall-free stretch; %0d results compared",
             results_checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/pbc_pkg.sv
sv/pbc_in_if.sv
sv/pbc_out_if.sv
sv/pbc_cfg_if.sv
sv/pbc_gain_div.sv
sv/pbc_chan_adj.sv
sv/pixel_brightness_contrast.sv
dv/pbc_pixel_checker.sv
dv/tb_pixel_brightness_contrast.sv
